FILE: src/abd_pkg.sv
// Shared types, constants and tables of the anchor box decoder.
package abd_pkg;

  localparam int OFF_W   = 16;
  localparam int ANC_W   = 17;
  localparam int SCALE_W = 16;
  localparam int CEN_W   = 17;
  localparam int SIZE_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_SCALE   = 1'd1;

  localparam logic [SCALE_W-1:0] CENTER_SCALE_RST = 16'd6554;
  localparam logic [SCALE_W-1:0] SIZE_SCALE_RST   = 16'd13107;

  localparam logic [CEN_W-1:0] CENTER_MAX = 17'd65536;

  // Pipeline depth from accepted word to output register.
  localparam int LAT     = 13;
  localparam int CEN_DLY = LAT - 4;

  typedef struct packed {
    logic [CEN_W-1:0]  box_cx;
    logic [CEN_W-1:0]  box_cy;
    logic [SIZE_W-1:0] box_w;
    logic [SIZE_W-1:0] box_h;
  } box_t;

  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [29:0] M5_Q32  = 30'd858993460;
  localparam logic [30:0] M3_Q32  = 31'd1431655766;

  function automatic logic [30:0] pow2_quarter(input logic [1:0] k);
    logic [30:0] v;
    case (k)
      2'd0:    v = 31'd1073741824;
      2'd1:    v = 31'd1276901417;
      2'd2:    v = 31'd1518500250;
      2'd3:    v = 31'd1805811301;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

endpackage

FILE: src/abd_if.sv
// Input and output channel interfaces of the anchor box decoder.
interface abd_in_if;
  import abd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OFF_W-1:0] offset_x;
  logic signed [OFF_W-1:0] offset_y;
  logic signed [OFF_W-1:0] offset_w;
  logic signed [OFF_W-1:0] offset_h;
  logic [ANC_W-1:0]        anchor_cx;
  logic [ANC_W-1:0]        anchor_cy;
  logic [ANC_W-1:0]        anchor_w;
  logic [ANC_W-1:0]        anchor_h;

  modport source (
    output valid, offset_x, offset_y, offset_w, offset_h,
    output anchor_cx, anchor_cy, anchor_w, anchor_h,
    input  ready
  );
  modport sink (
    input  valid, offset_x, offset_y, offset_w, offset_h,
    input  anchor_cx, anchor_cy, anchor_w, anchor_h,
    output ready
  );
endinterface

interface abd_out_if;
  import abd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CEN_W-1:0]  box_cx;
  logic [CEN_W-1:0]  box_cy;
  logic [SIZE_W-1:0] box_w;
  logic [SIZE_W-1:0] box_h;

  modport source (output valid, box_cx, box_cy, box_w, box_h, input ready);
  modport sink   (input  valid, box_cx, box_cy, box_w, box_h, output ready);
endinterface

FILE: src/abd_center.sv
// Centre decode lane: scaled offset, rounding, clamp, and delay to size lane depth.
module abd_center (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [abd_pkg::OFF_W-1:0] offset,
  input  logic [abd_pkg::ANC_W-1:0]        anchor_cen,
  input  logic [abd_pkg::ANC_W-1:0]        anchor_size,
  input  logic [abd_pkg::SCALE_W-1:0]      scale,
  output logic [abd_pkg::CEN_W-1:0]        center
);
  import abd_pkg::*;

  logic [32:0]             pr1;
  logic signed [OFF_W-1:0] off1;
  logic [ANC_W-1:0]        acen1;
  logic signed [49:0]      p2;
  logic [ANC_W-1:0]        acen2;
  logic signed [49:0]      ps;
  logic signed [26:0]      c3;
  logic [CEN_W-1:0]        c4;
  logic [CEN_W-1:0]        c4_next;
  logic [CEN_W-1:0]        dly [CEN_DLY];

  assign ps = p2 + 50'sd8388608;

  always_comb begin
    if (c3 < 27'sd0) begin
      c4_next = '0;
    end else if (c3 > $signed({10'd0, CENTER_MAX})) begin
      c4_next = CENTER_MAX;
    end else begin
      c4_next = c3[CEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1   <= 33'(scale) * 33'(anchor_size);
      off1  <= offset;
      acen1 <= anchor_cen;
      p2    <= 50'(off1) * 50'($signed({1'b0, pr1}));
      acen2 <= acen1;
      c3    <= 27'($signed(ps[49:24])) + 27'($signed({1'b0, acen2}));
      c4    <= c4_next;
      dly[0] <= c4;
      for (int i = 1; i < CEN_DLY; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign center = dly[CEN_DLY-1];

endmodule

FILE: src/abd_size.sv
// Size decode lane: clamped exponent, base-2 range reduction, Horner exp, scale, round and saturate.
module abd_size (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [abd_pkg::OFF_W-1:0] offset,
  input  logic [abd_pkg::ANC_W-1:0]        anchor_size,
  input  logic [abd_pkg::SCALE_W-1:0]      scale,
  output logic [abd_pkg::SIZE_W-1:0]       size
);
  import abd_pkg::*;

  localparam logic signed [32:0] EXP_HI  = 33'sd167772160;
  localparam logic signed [32:0] EXP_LO  = -33'sd167772160;
  localparam logic signed [59:0] LOG2E_Q30 = 60'sd1549082005;
  localparam logic signed [59:0] Z_BIAS  = 60'sd288230376151711744;
  localparam logic [5:0]         SH_BASE = 6'd46;

  logic signed [32:0] e1;
  logic signed [28:0] ec2;
  logic signed [28:0] ec_next;
  logic signed [59:0] zp;
  logic [34:0]        z3;
  logic [57:0]        up;
  logic [57:0]        d5;
  logic [58:0]        p6;
  logic [58:0]        p7;
  logic [59:0]        d8;
  logic [58:0]        p9;
  logic [58:0]        p10;
  logic [61:0]        pm;
  logic [30:0]        t5;
  logic [30:0]        t6;
  logic [28:0]        w7;
  logic [30:0]        t8;
  logic [30:0]        t9;
  logic [30:0]        t10;
  logic [31:0]        m11;
  logic [48:0]        q12;
  logic [49:0]        rnd;
  logic [49:0]        rsum;
  logic [49:0]        shv;
  logic [ANC_W-1:0]   as_d [11];
  logic [1:0]         k_d  [7];
  logic [5:0]         sh_d [9];
  logic [27:0]        u_d  [6];

  always_comb begin
    if (e1 > EXP_HI) begin
      ec_next = 29'(EXP_HI);
    end else if (e1 < EXP_LO) begin
      ec_next = 29'(EXP_LO);
    end else begin
      ec_next = 29'(e1);
    end
  end

  assign zp   = 60'(ec2) * LOG2E_Q30 + Z_BIAS;
  assign up   = 58'(z3[27:0]) * 58'(LN2_Q30);
  assign d5   = 58'(u_d[0]) * 58'(M5_Q32);
  assign p6   = 59'(u_d[1]) * 59'(t5);
  assign p7   = 59'(u_d[2]) * 59'(t6);
  assign d8   = 60'(w7) * 60'(M3_Q32);
  assign p9   = 59'(u_d[4]) * 59'(t8);
  assign p10  = 59'(u_d[5]) * 59'(t9);
  assign pm   = 62'(pow2_quarter(k_d[6])) * 62'(t10);
  assign rnd  = 50'd1 << (sh_d[8] - 6'd1);
  assign rsum = 50'(q12) + rnd;
  assign shv  = rsum >> sh_d[8];

  always_ff @(posedge clk) begin
    if (en) begin
      e1  <= 33'(offset) * 33'($signed({1'b0, scale}));
      ec2 <= ec_next;
      z3  <= zp[58:24];
      u_d[0]  <= up[57:30];
      k_d[0]  <= z3[29:28];
      sh_d[0] <= SH_BASE - {1'b0, z3[34:30]};
      t5  <= ONE_Q30 + 31'(d5[57:32]);
      t6  <= ONE_Q30 + 31'(p6[58:32]);
      w7  <= p7[58:30];
      t8  <= ONE_Q30 + 31'(d8[59:32]);
      t9  <= ONE_Q30 + 31'(p9[58:31]);
      t10 <= ONE_Q30 + 31'(p10[58:30]);
      m11 <= pm[61:30];
      q12 <= 49'(as_d[10]) * 49'(m11);
      size <= (|shv[49:32]) ? '1 : shv[31:0];
      as_d[0] <= anchor_size;
      for (int i = 1; i < 11; i++) begin
        as_d[i] <= as_d[i-1];
      end
      for (int i = 1; i < 7; i++) begin
        k_d[i] <= k_d[i-1];
      end
      for (int i = 1; i < 9; i++) begin
        sh_d[i] <= sh_d[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        u_d[i] <= u_d[i-1];
      end
    end
  end

endmodule

FILE: src/abd_skid.sv
// Output skid stage: holds one word while the sink stalls so the pipeline can advance.
module abd_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  abd_pkg::box_t   in_box,
  output logic            adv,
  abd_out_if.source       dout
);
  import abd_pkg::*;

  logic skid_valid;
  box_t skid_box;
  box_t out_box;

  assign adv     = !skid_valid;
  assign out_box = skid_valid ? skid_box : in_box;

  assign dout.valid  = skid_valid | in_valid;
  assign dout.box_cx = out_box.box_cx;
  assign dout.box_cy = out_box.box_cy;
  assign dout.box_w  = out_box.box_w;
  assign dout.box_h  = out_box.box_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid && dout.ready) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid && in_valid && !dout.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_box <= in_box;
    end
  end

endmodule

FILE: src/anchor_box_decoder.sv
// Top level of the anchor box decoder: registers, valid pipeline, lanes and skid.
//
//   channel  dir  word
//   din      in   four offsets and one anchor box
//   dout     out  one decoded box
//   cfg_*    in   register write, no read-back
//
// One word accepted per cycle while the skid stage is empty; each result
// passes the 13-stage pipeline of the size lanes, which the centre lanes match.
// Reset clears the valid pipeline and the skid stage and restores both scales.
// A stalled sink fills the skid stage; din.ready then drops and the whole
// pipeline holds until the skid word is taken.
module anchor_box_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [abd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abd_pkg::SCALE_W-1:0]       cfg_data,
  abd_in_if.sink                            din,
  abd_out_if.source                         dout
);
  import abd_pkg::*;

  logic [SCALE_W-1:0] center_scale;
  logic [SCALE_W-1:0] size_scale;
  logic               adv;
  logic [LAT-1:0]     vld;
  box_t               last_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_scale <= CENTER_SCALE_RST;
      size_scale   <= SIZE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_SCALE: center_scale <= cfg_data;
        REG_SIZE_SCALE:   size_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign din.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], din.valid};
    end
  end

  abd_center u_cen_x (
    .clk         (clk),
    .en          (adv),
    .offset      (din.offset_x),
    .anchor_cen  (din.anchor_cx),
    .anchor_size (din.anchor_w),
    .scale       (center_scale),
    .center      (last_box.box_cx)
  );

  abd_center u_cen_y (
    .clk         (clk),
    .en          (adv),
    .offset      (din.offset_y),
    .anchor_cen  (din.anchor_cy),
    .anchor_size (din.anchor_h),
    .scale       (center_scale),
    .center      (last_box.box_cy)
  );

  abd_size u_size_w (
    .clk         (clk),
    .en          (adv),
    .offset      (din.offset_w),
    .anchor_size (din.anchor_w),
    .scale       (size_scale),
    .size        (last_box.box_w)
  );

  abd_size u_size_h (
    .clk         (clk),
    .en          (adv),
    .offset      (din.offset_h),
    .anchor_size (din.anchor_h),
    .scale       (size_scale),
    .size        (last_box.box_h)
  );

  abd_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[LAT-1]),
    .in_box   (last_box),
    .adv      (adv),
    .dout     (dout)
  );

endmodule

FILE: src/abd_checker.sv
// Port-level checks on the anchor box decoder, bound to the top level.
module abd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [abd_pkg::CEN_W-1:0]  box_cx,
  input logic [abd_pkg::CEN_W-1:0]  box_cy
);
  import abd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output word valid straight after reset");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no output word pending");

  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("input stall not released after output taken");

  a_centre_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (box_cx <= CENTER_MAX) && (box_cy <= CENTER_MAX))
    else $error("centre outside unit range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

endmodule

bind anchor_box_decoder abd_checker u_abd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .box_cx    (dout.box_cx),
  .box_cy    (dout.box_cy)
);

FILE: tb/abd_checker.sv
// Checker for the anchor box decoder: tracks the scales, predicts each box and compares.
`timescale 1ns / 1ps

module abd_scoreboard
  import abd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data,
  abd_in_if                    din,
  abd_out_if                   dout,
  output int                   mismatches,
  output int                   boxes_seen,
  output int                   pending
);

  localparam longint      EXP_CAP   = 167772160;
  localparam longint      LOG2E_Q30 = 1549082005;
  localparam logic [63:0] ONE       = 64'd1073741824;
  localparam logic [63:0] LN2       = 64'd744261118;

  logic [SCALE_W-1:0] cen_var;
  logic [SCALE_W-1:0] size_var;
  box_t               boxes_due[$];

  function automatic logic [CEN_W-1:0] centre_of(input logic signed [OFF_W-1:0] off,
                                                 input logic [ANC_W-1:0] acen,
                                                 input logic [ANC_W-1:0] asize);
    longint o, v, a, ac, c;
    o  = off;
    v  = cen_var;
    a  = asize;
    ac = acen;
    c  = ((o * v * a + 64'sd8388608) >>> 24) + ac;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    return c[CEN_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] size_of(input logic signed [OFF_W-1:0] off,
                                                input logic [ANC_W-1:0] asize);
    longint      o, sv, e;
    logic [63:0] z, g, u, t, base, m, q, res;
    int          n, s;
    o  = off;
    sv = size_var;
    e  = o * sv;
    if (e > EXP_CAP) e = EXP_CAP;
    if (e < -EXP_CAP) e = -EXP_CAP;
    // log2 domain, biased by 16 so the integer part stays positive
    z = e * LOG2E_Q30 + (64'sd1 <<< 58);
    z = z >> 24;
    n = int'(z >> 30) - 16;
    g = z & 64'h3FFF_FFFF;
    case (g[29:28])
      2'd0:    base = 64'd1073741824;
      2'd1:    base = 64'd1276901417;
      2'd2:    base = 64'd1518500250;
      default: base = 64'd1805811301;
    endcase
    u = ({36'd0, g[27:0]} * LN2) >> 30;
    t = ONE;
    for (int d = 5; d >= 1; d--) t = ONE + ((u * t) >> 30) / 64'(d);
    m   = (base * t) >> 30;
    q   = 64'(asize) * m;
    s   = 30 - n;
    res = (q + (64'd1 << (s - 1))) >> s;
    return (res > 64'hFFFF_FFFF) ? '1 : res[SIZE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    box_t want;
    box_t got;
    if (rst) begin
      cen_var    = CENTER_SCALE_RST;
      size_var   = SIZE_SCALE_RST;
      mismatches = 0;
      boxes_seen = 0;
      boxes_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CENTER_SCALE) cen_var = cfg_data;
        else if (cfg_index == REG_SIZE_SCALE) size_var = cfg_data;
      end
      if (dout.valid && dout.ready) begin
        got.box_cx = dout.box_cx;
        got.box_cy = dout.box_cy;
        got.box_w  = dout.box_w;
        got.box_h  = dout.box_h;
        boxes_seen++;
        if (boxes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected box cx=%h cy=%h w=%h h=%h", $realtime,
                     got.box_cx, got.box_cy, got.box_w, got.box_h);
        end else begin
          want = boxes_due.pop_front();
          if (got.box_cx != want.box_cx || got.box_cy != want.box_cy ||
              got.box_w != want.box_w || got.box_h != want.box_h) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: box mismatch exp cx=%h cy=%h w=%h h=%h got cx=%h cy=%h w=%h h=%h",
                       $realtime, want.box_cx, want.box_cy, want.box_w, want.box_h,
                       got.box_cx, got.box_cy, got.box_w, got.box_h);
          end
        end
      end
      if (din.valid && din.ready) begin
        want.box_cx = centre_of(din.offset_x, din.anchor_cx, din.anchor_w);
        want.box_cy = centre_of(din.offset_y, din.anchor_cy, din.anchor_h);
        want.box_w  = size_of(din.offset_w, din.anchor_w);
        want.box_h  = size_of(din.offset_h, din.anchor_h);
        boxes_due.insert(boxes_due.size(), want);
      end
    end
    pending = boxes_due.size();
  end

endmodule

FILE: tb/tb_anchor_box_decoder.sv
// Testbench top of the anchor box decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_anchor_box_decoder;
  import abd_pkg::*;

  localparam int N_PHASES    = 8;
  localparam int PHASE_BOXES = 140;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
    logic signed [OFF_W-1:0] ow;
    logic signed [OFF_W-1:0] oh;
    logic [ANC_W-1:0]        acx;
    logic [ANC_W-1:0]        acy;
    logic [ANC_W-1:0]        aw;
    logic [ANC_W-1:0]        ah;
  } box_in_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCALE_W-1:0] cfg_data;
  int                 mismatches;
  int                 boxes_seen;
  int                 pending;
  int                 idle_pct;
  int                 stall_pct;
  int                 cycles = 0;

  abd_in_if  din_if ();
  abd_out_if dout_if ();

  anchor_box_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  abd_scoreboard i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .din        (din_if),
    .dout       (dout_if),
    .mismatches (mismatches),
    .boxes_seen (boxes_seen),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d boxes outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic box_in_t mk(input int ox, input int oy, input int ow, input int oh,
                                 input int acx, input int acy, input int aw, input int ah);
    box_in_t b;
    b.ox  = OFF_W'(ox);
    b.oy  = OFF_W'(oy);
    b.ow  = OFF_W'(ow);
    b.oh  = OFF_W'(oh);
    b.acx = ANC_W'(acx);
    b.acy = ANC_W'(acy);
    b.aw  = ANC_W'(aw);
    b.ah  = ANC_W'(ah);
    return b;
  endfunction

  function automatic logic signed [OFF_W-1:0] rand_offset();
    if ($urandom_range(3) == 0) return OFF_W'($urandom);
    return OFF_W'($urandom_range(2048)) - 16'sd1024;
  endfunction

  function automatic logic [ANC_W-1:0] rand_anchor();
    case ($urandom_range(7))
      0:       return ANC_W'($urandom);
      1:       return '0;
      2:       return ANC_W'(65536);
      default: return ANC_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic box_in_t rand_box();
    box_in_t b;
    b.ox  = rand_offset();
    b.oy  = rand_offset();
    b.ow  = rand_offset();
    b.oh  = rand_offset();
    b.acx = rand_anchor();
    b.acy = rand_anchor();
    b.aw  = rand_anchor();
    b.ah  = rand_anchor();
    return b;
  endfunction

  task automatic push_box(input box_in_t b);
    while ($urandom_range(99) < idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.offset_x  <= b.ox;
    din_if.offset_y  <= b.oy;
    din_if.offset_w  <= b.ow;
    din_if.offset_h  <= b.oh;
    din_if.anchor_cx <= b.acx;
    din_if.anchor_cy <= b.acy;
    din_if.anchor_w  <= b.aw;
    din_if.anchor_h  <= b.ah;
    do @(posedge clk); while (!din_if.ready);
  endtask

  // hold the input until every box is back and the pipeline is empty
  task automatic drain();
    din_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  task automatic set_scales(input logic [SCALE_W-1:0] cs, input logic [SCALE_W-1:0] ss);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTER_SCALE;
    cfg_data  <= cs;
    @(posedge clk);
    cfg_index <= REG_SIZE_SCALE;
    cfg_data  <= ss;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [SCALE_W-1:0] cs, ss;
    rst               = 1'b1;
    idle_pct          = 0;
    stall_pct         = 0;
    cfg_we            = 1'b0;
    cfg_index         = REG_CENTER_SCALE;
    cfg_data          = '0;
    din_if.valid      = 1'b0;
    din_if.offset_x   = '0;
    din_if.offset_y   = '0;
    din_if.offset_w   = '0;
    din_if.offset_h   = '0;
    din_if.anchor_cx  = '0;
    din_if.anchor_cy  = '0;
    din_if.anchor_w   = '0;
    din_if.anchor_h   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset scales
    push_box(mk(0, 0, 0, 0, 0, 0, 0, 0));
    push_box(mk(32767, -32768, 32767, -32768, 65536, 65536, 65536, 65536));
    push_box(mk(-32768, 32767, -32768, 32767, 131071, 131071, 131071, 131071));
    push_box(mk(1000, -1000, 500, -500, 30000, 40000, 0, 0));
    push_box(mk(1, -1, 1, -1, 32768, 32768, 1, 1));
    push_box(mk(32767, 32767, 0, 0, 65536, 60000, 131071, 131071));
    push_box(mk(-32768, -32768, 0, 0, 0, 5000, 131071, 131071));
    push_box(mk(0, 0, 32767, -32768, 0, 0, 131071, 131071));
    push_box(mk(256, -256, 256, -256, 32768, 32768, 65536, 65536));
    push_box(mk(0, 0, 12800, 12801, 32768, 32768, 65536, 65536));
    push_box(mk(0, 0, -12800, -12801, 32768, 32768, 65536, 65536));
    push_box(mk(0, 0, 0, 0, 131071, 131071, 100, 100));
    push_box(mk(-1, -1, -1, -1, 1, 1, 1, 1));
    push_box(mk(-1024, 1024, 1024, -1024, 20000, 45000, 12000, 50000));

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0:       begin cs = 16'd6554;  ss = 16'd13107; end
        1:       begin cs = 16'd0;     ss = 16'd65535; end
        2:       begin cs = 16'd65535; ss = 16'd0;     end
        4:       begin cs = 16'd32768; ss = 16'd65535; end
        6:       begin cs = 16'd65535; ss = 16'd1;     end
        7:       begin cs = 16'd6554;  ss = 16'd2000;  end
        default: begin cs = SCALE_W'($urandom_range(65535));
                       ss = SCALE_W'($urandom_range(65535)); end
      endcase
      set_scales(cs, ss);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 63; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat (PHASE_BOXES) push_box(rand_box());
    end

    drain();
    repeat (LAT + 8) @(posedge clk);
    $display("Decoded %0d boxes under %0d scale settings, from zero to full scale,",
             boxes_seen, N_PHASES);
    $display("with sender gaps, result stalls and both together; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
